### design/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types and constants of the sensor timestamp aligner.
// ----------------------------------------------------------------------------
package sta_pkg;

   localparam int TimeW     = 63;
   localparam int StampW    = 64;
   localparam int FieldW    = 16;
   localparam int IntervalW = 30;
   localparam int ResyncW   = 42;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 42;

   localparam logic [IntervalW-1:0] DataIntervalReset  = IntervalW'(8000000);
   localparam logic [IntervalW-1:0] WindowEpsilonReset = IntervalW'(1000000);
   localparam logic [ResyncW-1:0]   ResyncIntervalReset = ResyncW'(64'd5000000000);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DATA_INTERVAL   = 2'd0,
      CSR_WINDOW_EPSILON  = 2'd1,
      CSR_RESYNC_INTERVAL = 2'd2,
      CSR_TIMER_MODE      = 2'd3
   } csr_index_type;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [TimeW-1:0]         host_time_ns;
      logic [TimeW-1:0]         device_time_ns;
      logic signed [FieldW-1:0] field_x;
      logic signed [FieldW-1:0] field_y;
      logic signed [FieldW-1:0] field_z;
   } req_beat_type;

   typedef struct packed {
      logic [StampW-1:0]        stamp_ns;
      logic signed [FieldW-1:0] out_field_x;
      logic signed [FieldW-1:0] out_field_y;
      logic signed [FieldW-1:0] out_field_z;
   } rsp_beat_type;

   typedef struct packed {
      logic [IntervalW-1:0] data_interval_ns;
      logic [IntervalW-1:0] window_epsilon_ns;
      logic [ResyncW-1:0]   resync_interval_ns;
      logic                 timer_mode;
   } cfg_type;

   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } rsp_load_type;

   typedef struct packed {
      logic publish_enabled;
      logic sync_pending;
   } core_status_type;

endpackage

### design/sta_csr.sv
// ----------------------------------------------------------------------------
// sta_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module sta_csr
   import sta_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DATA_INTERVAL:   cfg_in.data_interval_ns   = csr_wdata[IntervalW-1:0];
            CSR_WINDOW_EPSILON:  cfg_in.window_epsilon_ns  = csr_wdata[IntervalW-1:0];
            CSR_RESYNC_INTERVAL: cfg_in.resync_interval_ns = csr_wdata[ResyncW-1:0];
            CSR_TIMER_MODE:      cfg_in.timer_mode         = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_interval_ns   <= DataIntervalReset;
         cfg_ff.window_epsilon_ns  <= WindowEpsilonReset;
         cfg_ff.resync_interval_ns <= ResyncIntervalReset;
         cfg_ff.timer_mode         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/sta_req_stage.sv
// ----------------------------------------------------------------------------
// sta_req_stage
// Input register: holds one accepted request beat until the core takes it.
// ----------------------------------------------------------------------------
module sta_req_stage
   import sta_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   input  logic         advance,
   output logic         s1_valid,
   output req_beat_type s1_beat
);

   logic         valid_ff;
   logic         valid_in;
   req_beat_type beat_ff;
   logic         accept;

   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= req_data;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_beat  = beat_ff;

endmodule

### design/sta_align_core.sv
// ----------------------------------------------------------------------------
// sta_align_core
// Alignment state and the per-beat resync, hold and publish decisions.
// ----------------------------------------------------------------------------
module sta_align_core
   import sta_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            step,
   input  req_beat_type    beat,
   output rsp_load_type    load,
   output core_status_type status
);

   logic                     seen_first_ff, seen_first_in;
   logic                     sync_pending_ff, sync_pending_in;
   logic                     enabled_ff, enabled_in;
   logic [TimeW-1:0]         prev_host_ff, prev_host_in;
   logic [TimeW-1:0]         host_zero_ff, host_zero_in;
   logic [StampW-1:0]        offset_ff, offset_in;
   logic [StampW-1:0]        last_stamp_ff, last_stamp_in;
   logic [StampW-1:0]        held_stamp_ff, held_stamp_in;
   logic signed [FieldW-1:0] held_x_ff, held_x_in;
   logic signed [FieldW-1:0] held_y_ff, held_y_in;
   logic signed [FieldW-1:0] held_z_ff, held_z_in;

   logic                     is_tick;
   logic [StampW-1:0]        now_w;
   logic [StampW-1:0]        dev_w;
   logic signed [StampW-1:0] gap;
   logic signed [StampW-1:0] win_lo;
   logic signed [StampW-1:0] win_hi;
   logic signed [StampW-1:0] elapsed;
   logic signed [StampW-1:0] resync_s;
   logic                     in_window;
   logic                     capture;
   logic                     arm;
   logic                     enabled_next;
   logic [StampW-1:0]        sample_stamp;
   logic [StampW-1:0]        cand_stamp;
   logic                     pub_try;
   logic                     pub_ok;

   assign is_tick = (beat.req_type == REQ_TICK);
   assign now_w   = {1'b0, beat.host_time_ns};
   assign dev_w   = {1'b0, beat.device_time_ns};

   // window edges; low edge goes negative when epsilon exceeds the interval
   assign win_lo = {{(StampW-IntervalW){1'b0}}, cfg.data_interval_ns}
                 - {{(StampW-IntervalW){1'b0}}, cfg.window_epsilon_ns};
   assign win_hi = {{(StampW-IntervalW){1'b0}}, cfg.data_interval_ns}
                 + {{(StampW-IntervalW){1'b0}}, cfg.window_epsilon_ns};

   assign gap       = now_w - {1'b0, prev_host_ff};
   assign in_window = (gap >= win_lo) && (gap <= win_hi);
   assign capture   = !is_tick && seen_first_ff && sync_pending_ff && in_window;

   // a capture sets host zero to now, so elapsed counts as zero and arm stays low
   assign elapsed  = now_w - {1'b0, host_zero_ff};
   assign resync_s = {{(StampW-ResyncW){1'b0}}, cfg.resync_interval_ns};
   assign arm      = !capture && (cfg.resync_interval_ns != '0) && (elapsed >= resync_s);

   assign enabled_next = enabled_ff || capture;
   assign sample_stamp = capture ? now_w : (dev_w + offset_ff);

   always_comb begin
      if (is_tick) begin
         pub_try    = cfg.timer_mode && enabled_ff;
         cand_stamp = held_stamp_ff;
      end else begin
         pub_try    = seen_first_ff && enabled_next && !cfg.timer_mode;
         cand_stamp = sample_stamp;
      end
   end

   assign pub_ok = pub_try && (cand_stamp >= last_stamp_ff);

   always_comb begin
      seen_first_in   = seen_first_ff;
      sync_pending_in = sync_pending_ff;
      enabled_in      = enabled_ff;
      prev_host_in    = prev_host_ff;
      host_zero_in    = host_zero_ff;
      offset_in       = offset_ff;
      last_stamp_in   = last_stamp_ff;
      held_stamp_in   = held_stamp_ff;
      held_x_in       = held_x_ff;
      held_y_in       = held_y_ff;
      held_z_in       = held_z_ff;
      if (step) begin
         if (pub_ok) begin
            last_stamp_in = cand_stamp;
         end
         if (!is_tick) begin
            prev_host_in = beat.host_time_ns;
            if (!seen_first_ff) begin
               seen_first_in = 1'b1;
               host_zero_in  = beat.host_time_ns;
            end else begin
               if (capture) begin
                  host_zero_in    = beat.host_time_ns;
                  offset_in       = now_w - dev_w;
                  sync_pending_in = 1'b0;
               end
               if (arm) begin
                  sync_pending_in = 1'b1;
               end
               enabled_in = enabled_next;
               if (enabled_next) begin
                  held_stamp_in = sample_stamp;
                  held_x_in     = beat.field_x;
                  held_y_in     = beat.field_y;
                  held_z_in     = beat.field_z;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff   <= 1'b0;
         sync_pending_ff <= 1'b1;
         enabled_ff      <= 1'b0;
         last_stamp_ff   <= '0;
      end else begin
         seen_first_ff   <= seen_first_in;
         sync_pending_ff <= sync_pending_in;
         enabled_ff      <= enabled_in;
         last_stamp_ff   <= last_stamp_in;
      end
   end

   // only read once the flags above say they were written
   always_ff @(posedge clock) begin
      prev_host_ff  <= prev_host_in;
      host_zero_ff  <= host_zero_in;
      offset_ff     <= offset_in;
      held_stamp_ff <= held_stamp_in;
      held_x_ff     <= held_x_in;
      held_y_ff     <= held_y_in;
      held_z_ff     <= held_z_in;
   end

   always_comb begin
      load.valid            = step && pub_ok;
      load.beat.stamp_ns    = cand_stamp;
      load.beat.out_field_x = is_tick ? held_x_ff : beat.field_x;
      load.beat.out_field_y = is_tick ? held_y_ff : beat.field_y;
      load.beat.out_field_z = is_tick ? held_z_ff : beat.field_z;
   end

   assign status.publish_enabled = enabled_ff;
   assign status.sync_pending    = sync_pending_ff;

endmodule

### design/sta_rsp_stage.sv
// ----------------------------------------------------------------------------
// sta_rsp_stage
// Output register: holds a result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module sta_rsp_stage
   import sta_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_load_type load,
   output logic         out_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_data
);

   logic         valid_ff;
   logic         valid_in;
   rsp_beat_type data_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         data_ff <= load.beat;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### design/sensor_timestamp_aligner_unit.sv
// ----------------------------------------------------------------------------
// sensor_timestamp_aligner_unit
// Maps device sample timestamps onto host time and publishes aligned samples.
// Path: input register, alignment core, output register driving rsp_valid.
// Throughput: one beat per cycle unless the output is blocked; the
// alignment state is updated as a beat moves between the two registers.
// Reset: synchronous; sets sync_pending, clears other flags and last stamp,
// loads default config; no clearing pass, beats are taken right after reset.
// ----------------------------------------------------------------------------
module sensor_timestamp_aligner_unit
   import sta_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_beat_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_beat_type        rsp_data,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type         cfg;
   logic            s1_valid;
   req_beat_type    s1_beat;
   logic            out_free;
   logic            advance;
   rsp_load_type    load;
   core_status_type status;

   // a beat leaves the input register whether or not it makes a result
   assign advance = s1_valid && out_free;

   sta_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sta_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_beat   (s1_beat)
   );

   sta_align_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .beat   (s1_beat),
      .load   (load),
      .status (status)
   );

   sta_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_enable_sticky: assert property (@(posedge clock) disable iff (reset)
      status.publish_enabled |=> status.publish_enabled)
      else $error("publish enable dropped");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> out_free)
      else $error("result loaded over a waiting beat");

   a_load_only_enabled: assert property (@(posedge clock) disable iff (reset)
      load.valid |=> status.publish_enabled)
      else $error("result produced while publishing disabled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid && rsp_valid && !rsp_ready))
      else $error("request stalled without a blocked output");

endmodule

### test/sta_align_checker.sv
// ----------------------------------------------------------------------------
// sta_align_checker
// Passive checker of the sensor timestamp aligner. It tracks the register
// writes, predicts the result beat, if any, of every accepted request beat and
// compares each accepted result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module sta_align_checker
   import sta_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  req_beat_type        req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_beat_type        rsp_data,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  mismatch_count,
   output int                  outstanding
);

   cfg_type                  cfg;
   logic                     seen_first;
   logic                     sync_pending;
   logic                     publish_enabled;
   logic [StampW-1:0]        prev_host;
   logic [StampW-1:0]        host_zero;
   logic [StampW-1:0]        device_zero;
   logic [StampW-1:0]        last_stamp;
   logic [StampW-1:0]        held_device;
   logic signed [FieldW-1:0] held_x;
   logic signed [FieldW-1:0] held_y;
   logic signed [FieldW-1:0] held_z;
   rsp_beat_type             aligned_stamps[$];
   rsp_beat_type             oldest;

   // signed difference of two 63-bit host or device times
   function automatic logic signed [63:0] time_diff(input logic [StampW-1:0] a,
                                                    input logic [StampW-1:0] b);
      return $signed({1'b0, a[TimeW-1:0]}) - $signed({1'b0, b[TimeW-1:0]});
   endfunction

   task automatic release_held();
      logic [StampW-1:0] stamp;
      rsp_beat_type      beat;
      stamp = host_zero + (held_device - device_zero);
      // a stamp earlier than the last one is dropped
      if (stamp >= last_stamp) begin
         last_stamp = stamp;
         beat.stamp_ns = stamp;
         beat.out_field_x = held_x;
         beat.out_field_y = held_y;
         beat.out_field_z = held_z;
         aligned_stamps.push_back(beat);
      end
   endtask

   task automatic predict_alignment(input req_beat_type b);
      logic [StampW-1:0]  now;
      logic [StampW-1:0]  dev;
      logic signed [63:0] gap;
      logic signed [63:0] lo;
      logic signed [63:0] hi;
      now = {1'b0, b.host_time_ns};
      dev = {1'b0, b.device_time_ns};
      if (b.req_type == REQ_TICK) begin
         if (cfg.timer_mode && publish_enabled) release_held();
      end else if (!seen_first) begin
         seen_first = 1'b1;
         prev_host = now;
         host_zero = now;
      end else begin
         if (sync_pending) begin
            gap = time_diff(now, prev_host);
            lo = $signed({34'd0, cfg.data_interval_ns}) - $signed({34'd0, cfg.window_epsilon_ns});
            hi = $signed({34'd0, cfg.data_interval_ns}) + $signed({34'd0, cfg.window_epsilon_ns});
            if (gap >= lo && gap <= hi) begin
               host_zero = now;
               device_zero = dev;
               sync_pending = 1'b0;
               publish_enabled = 1'b1;
            end
         end
         if (publish_enabled) begin
            held_x = b.field_x;
            held_y = b.field_y;
            held_z = b.field_z;
            held_device = dev;
            if (!cfg.timer_mode) release_held();
         end
         if (cfg.resync_interval_ns != '0 &&
             time_diff(now, host_zero) >= $signed({22'd0, cfg.resync_interval_ns}))
            sync_pending = 1'b1;
         prev_host = now;
      end
   endtask

   task automatic check_field(input string name, input logic [StampW-1:0] want,
                              input logic [StampW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.data_interval_ns = DataIntervalReset;
         cfg.window_epsilon_ns = WindowEpsilonReset;
         cfg.resync_interval_ns = ResyncIntervalReset;
         cfg.timer_mode = 1'b0;
         seen_first = 1'b0;
         sync_pending = 1'b1;
         publish_enabled = 1'b0;
         prev_host = '0;
         host_zero = '0;
         device_zero = '0;
         last_stamp = '0;
         held_device = '0;
         held_x = '0;
         held_y = '0;
         held_z = '0;
         aligned_stamps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_DATA_INTERVAL: begin
                  cfg.data_interval_ns = csr_wdata[IntervalW-1:0];
               end
               CSR_WINDOW_EPSILON: begin
                  cfg.window_epsilon_ns = csr_wdata[IntervalW-1:0];
               end
               CSR_RESYNC_INTERVAL: begin
                  cfg.resync_interval_ns = csr_wdata[ResyncW-1:0];
               end
               CSR_TIMER_MODE: begin
                  cfg.timer_mode = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         // results of this edge cannot stem from the request beat of this edge
         if (rsp_valid && rsp_ready) begin
            if (aligned_stamps.size() == 0) begin
               $error("result beat with no prediction waiting, stamp_ns %h", rsp_data.stamp_ns);
               mismatch_count++;
            end else begin
               oldest = aligned_stamps.pop_front();
               check_field("stamp_ns", oldest.stamp_ns, rsp_data.stamp_ns);
               check_field("out_field_x", oldest.out_field_x, rsp_data.out_field_x);
               check_field("out_field_y", oldest.out_field_y, rsp_data.out_field_y);
               check_field("out_field_z", oldest.out_field_z, rsp_data.out_field_z);
            end
         end
         if (req_valid && req_ready) predict_alignment(req_data);
      end
      outstanding = aligned_stamps.size();
   end

endmodule

### test/tb_sensor_timestamp_aligner_unit.sv
// ----------------------------------------------------------------------------
// tb_sensor_timestamp_aligner_unit
// Drives sample and tick beats into the aligner under a series of register
// settings, with random gaps on both channels, and takes the verdict from
// the checker that predicts and compares the published stamps.
// ----------------------------------------------------------------------------
module tb_sensor_timestamp_aligner_unit;
   import sta_pkg::*;

   localparam int CycleLimit = 500000;
   localparam int PhaseBeats = 120;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_beat_type        req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_beat_type        rsp_data;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   int                  mismatch_count;
   int                  outstanding;

   bit                  no_idle;
   cfg_type             cfg_now;
   logic [TimeW-1:0]    host_now;
   logic [TimeW-1:0]    dev_now;

   sensor_timestamp_aligner_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sta_align_checker align_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: a fresh stall before every result beat
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         repeat (stall) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   function automatic logic [TimeW-1:0] rand63();
      return TimeW'({$urandom, $urandom});
   endfunction

   function automatic cfg_type make_cfg(input logic [IntervalW-1:0] interval,
                                        input logic [IntervalW-1:0] epsilon,
                                        input logic [ResyncW-1:0] resync,
                                        input logic mode);
      cfg_type c;
      c.data_interval_ns = interval;
      c.window_epsilon_ns = epsilon;
      c.resync_interval_ns = resync;
      c.timer_mode = mode;
      return c;
   endfunction

   function automatic req_beat_type make_beat(input logic kind, input logic [TimeW-1:0] host,
                                              input logic [TimeW-1:0] dev,
                                              input logic [FieldW-1:0] x,
                                              input logic [FieldW-1:0] y,
                                              input logic [FieldW-1:0] z);
      req_beat_type b;
      b.req_type = kind;
      b.host_time_ns = host;
      b.device_time_ns = dev;
      b.field_x = x;
      b.field_y = y;
      b.field_z = z;
      return b;
   endfunction

   // entered and left just after a falling edge
   task automatic send_req(input req_beat_type b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_sample(input logic [TimeW-1:0] host, input logic [TimeW-1:0] dev,
                              input logic [FieldW-1:0] x, input logic [FieldW-1:0] y,
                              input logic [FieldW-1:0] z);
      send_req(make_beat(REQ_SAMPLE, host, dev, x, y, z));
   endtask

   // a tick carries junk in every other field
   task automatic send_tick();
      send_req(make_beat(REQ_TICK, rand63(), rand63(), FieldW'($urandom),
                         FieldW'($urandom), FieldW'($urandom)));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      // a beat without a result may still be in the pipeline
      repeat (4) @(negedge clock);
   endtask

   task automatic load_config(input cfg_type c);
      csr_we <= 1'b1;
      csr_index <= CSR_DATA_INTERVAL;
      csr_wdata <= CsrDataW'(c.data_interval_ns);
      @(negedge clock);
      csr_index <= CSR_WINDOW_EPSILON;
      csr_wdata <= CsrDataW'(c.window_epsilon_ns);
      @(negedge clock);
      csr_index <= CSR_RESYNC_INTERVAL;
      csr_wdata <= CsrDataW'(c.resync_interval_ns);
      @(negedge clock);
      csr_index <= CSR_TIMER_MODE;
      csr_wdata <= CsrDataW'(c.timer_mode);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_now = c;
   endtask

   // mostly gaps inside the capture window, plus window edges, long gaps,
   // host time stepping back and device time stepping back
   task automatic send_stream_sample();
      longint lo;
      longint hi;
      longint hgap;
      longint dgap;
      int     pick;
      lo = longint'(cfg_now.data_interval_ns) - longint'(cfg_now.window_epsilon_ns);
      hi = longint'(cfg_now.data_interval_ns) + longint'(cfg_now.window_epsilon_ns);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         hgap = lo + longint'($urandom_range(0, 2 * cfg_now.window_epsilon_ns));
      end else if (pick < 77) begin
         case ($urandom_range(0, 3))
            0: hgap = lo;
            1: hgap = lo - 1;
            2: hgap = hi;
            default: hgap = hi + 1;
         endcase
      end else if (pick < 88) begin
         hgap = longint'($urandom);
      end else if (pick < 94) begin
         hgap = -longint'($urandom_range(1, 2000000000));
      end else begin
         hgap = longint'($urandom) << 8;
      end
      if (pick >= 77) begin
         dgap = longint'(cfg_now.data_interval_ns) + longint'($urandom_range(0, 2000));
      end else if ($urandom_range(0, 9) != 0) begin
         dgap = hgap + longint'($urandom_range(0, 2000)) - 1000;
      end else begin
         dgap = -longint'($urandom_range(1, 2 * cfg_now.data_interval_ns + 1000));
      end
      // keep both clocks from wrapping below zero
      if (longint'(host_now) + hgap < 0) hgap = -hgap;
      if (longint'(dev_now) + dgap < 0) dgap = -dgap;
      host_now = host_now + hgap[TimeW-1:0];
      dev_now = dev_now + dgap[TimeW-1:0];
      send_sample(host_now, dev_now, FieldW'($urandom), FieldW'($urandom), FieldW'($urandom));
   endtask

   task automatic run_phase(input cfg_type c, input bit to_top);
      logic [TimeW-1:0] jump;
      drain_results();
      load_config(c);
      // both clocks move by the same amount so that stamps keep rising
      if (to_top)
         jump = 63'h7FFC_0000_0000_0000 - ((host_now > dev_now) ? host_now : dev_now);
      else
         jump = rand63() >> 14;
      host_now = host_now + jump;
      dev_now = dev_now + jump;
      for (int n = 0; n < PhaseBeats; n++) begin
         if (n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < (c.timer_mode ? 35 : 8))
            send_tick();
         else
            send_stream_sample();
      end
      no_idle = 1'b0;
      if (to_top) begin
         send_sample('1, '1, 16'sh7FFF, 16'sh8000, 16'shFFFF);
         send_sample('1, '1, 16'sh8000, 16'sh7FFF, 16'sh0000);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_idle = 1'b0;
      cfg_now = make_cfg(DataIntervalReset, WindowEpsilonReset, ResyncIntervalReset, 1'b0);
      host_now = '0;
      dev_now = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tick outside timer mode, before publishing is enabled
      send_tick();
      drain_results();
      load_config(make_cfg(DataIntervalReset, WindowEpsilonReset, ResyncIntervalReset, 1'b1));
      // timer mode, still not enabled
      send_tick();
      // first sample at host time zero
      send_sample(63'd0, 63'd1000, 16'sh8000, 16'sh7FFF, 16'sh0000);
      // gap of exactly the interval: sync, sample held only
      send_sample(63'd8000000, 63'd2000, 16'sh7FFF, 16'sh8000, 16'shFFFF);
      send_tick();
      send_tick();
      // device time steps back, the tick then drops the stamp
      send_sample(63'd16000000, 63'd1500, 16'sh0001, 16'sh0002, 16'sh0003);
      send_tick();
      send_sample(63'd24000000, 63'd9002000, 16'sh0004, 16'sh0005, 16'sh0006);
      send_tick();

      drain_results();
      // epsilon above the interval puts the window's low edge below zero
      load_config(make_cfg('0, IntervalW'(1000000000), ResyncW'(1), 1'b0));
      send_sample(63'd30000000, 63'd15002000, 16'sh1234, 16'shEDCB, 16'sh0F0F);
      // host time goes back but stays inside the window
      send_sample(63'd29999995, 63'd15003000, 16'shF0F0, 16'sh5555, 16'shAAAA);
      // tick outside timer mode once enabled
      send_tick();
      send_sample(63'd30000005, 63'd15004000, 16'sh0101, 16'sh0202, 16'sh0303);
      // just above the window's high edge, then exactly on it
      send_sample(63'd1030000006, 63'd1015004000, 16'sh0404, 16'sh0505, 16'sh0606);
      send_sample(63'd2030000006, 63'd2015004000, 16'sh0707, 16'sh0808, 16'sh0909);
      send_sample(63'd2030000010, 63'd2015005000, 16'sh0A0A, 16'sh0B0B, 16'sh0C0C);
      // just below the low edge, then exactly on it
      send_sample(63'd1030000009, 63'd2015006000, 16'sh0D0D, 16'sh0E0E, 16'sh0F0F);
      send_sample(63'd30000009, 63'd2015007000, 16'sh1111, 16'sh2222, 16'sh3333);

      host_now = 63'd4000000000;
      dev_now = 63'd3000000000;
      run_phase(make_cfg(DataIntervalReset, WindowEpsilonReset, ResyncIntervalReset, 1'b0),
                1'b0);
      run_phase(make_cfg(IntervalW'(8000000), IntervalW'(1000000), ResyncW'(24000000), 1'b0),
                1'b0);
      run_phase(make_cfg('0, '0, '0, 1'b0), 1'b0);
      run_phase(make_cfg(IntervalW'(1000000000), IntervalW'(1000000000),
                         ResyncW'(64'd3600000000000), 1'b1), 1'b0);
      run_phase(make_cfg(IntervalW'(1000), IntervalW'(5000), ResyncW'(2500), 1'b0), 1'b0);
      run_phase(make_cfg(IntervalW'(5000000), IntervalW'(200000), ResyncW'(10000000), 1'b1),
                1'b0);
      repeat (2) begin
         run_phase(make_cfg(IntervalW'($urandom_range(0, 1000000000)),
                            IntervalW'($urandom_range(0, 1000000000)),
                            ResyncW'(longint'($urandom) * $urandom_range(0, 838)),
                            1'($urandom_range(0, 1))), 1'b0);
      end
      run_phase(make_cfg(IntervalW'(1000000000), '0, ResyncW'(1), 1'b0), 1'b1);

      drain_results();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
